FILE: hw/rtl/mfd_pkg.sv
package mfd_pkg;

    // Frame delimiters.
    localparam logic [7:0] SYNC_FIRST  = 8'hCC;
    localparam logic [7:0] SYNC_SECOND = 8'hDD;
    localparam logic [7:0] SYNC_THIRD  = 8'hEE;
    localparam logic [7:0] END_MARK    = 8'hFF;

    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 4;
    localparam int VOLT_W  = 12;
    localparam int COUNT_W = 32;

    // Output word layout: range_mode, voltage_code, freq_count from bit 0 up.
    localparam int OUT_TDATA_W = MODE_W + VOLT_W + COUNT_W;

    typedef struct packed {
        logic [COUNT_W-1:0] freq_count;
        logic [VOLT_W-1:0]  voltage_code;
        logic [MODE_W-1:0]  range_mode;
        logic               mode_changed;
    } t_result;

endpackage

FILE: hw/rtl/mfd_in_reg.sv
module mfd_in_reg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [mfd_pkg::BYTE_W-1:0] i_byte,
    output logic                    o_valid,
    input  logic                    i_take,
    output logic [mfd_pkg::BYTE_W-1:0] o_byte
);
    import mfd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // The register may refill in the same cycle that the decoder takes its word.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

FILE: hw/rtl/mfd_deframer.sv
module mfd_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mfd_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_step,
    output logic                       o_emit,
    output mfd_pkg::t_result           o_result
);
    import mfd_pkg::*;

    typedef enum logic [3:0] {
        POS_SYNC1 = 4'd0,
        POS_SYNC2 = 4'd1,
        POS_SYNC3 = 4'd2,
        POS_HEAD  = 4'd3,
        POS_VLOW  = 4'd4,
        POS_CNT0  = 4'd5,
        POS_CNT1  = 4'd6,
        POS_CNT2  = 4'd7,
        POS_CNT3  = 4'd8,
        POS_END   = 4'd9
    } t_pos;

    t_pos               r_pos;
    logic [MODE_W-1:0]  r_pend_mode;
    logic [VOLT_W-1:0]  r_pend_volt;
    logic [COUNT_W-1:0] r_pend_count;
    logic [MODE_W-1:0]  r_acc_mode;

    assign o_emit = (r_pos == POS_END) && (i_byte == END_MARK);

    always_comb begin
        o_result.range_mode   = r_pend_mode;
        o_result.voltage_code = r_pend_volt;
        o_result.freq_count   = r_pend_count;
        o_result.mode_changed = (r_pend_mode != r_acc_mode);
    end

    // Each count byte shifts in from the bottom, so after four bytes the old
    // contents are gone and no clear is needed between frames.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_SYNC1;
            r_acc_mode <= '0;
        end else if (i_step) begin
            case (r_pos)
                POS_SYNC1: begin
                    r_pos <= (i_byte == SYNC_FIRST) ? POS_SYNC2 : POS_SYNC1;
                end
                POS_SYNC2: begin
                    r_pos <= (i_byte == SYNC_SECOND) ? POS_SYNC3 : POS_SYNC1;
                end
                POS_SYNC3: begin
                    r_pos <= (i_byte == SYNC_THIRD) ? POS_HEAD : POS_SYNC1;
                end
                POS_HEAD: begin
                    r_pend_mode       <= i_byte[7:4];
                    r_pend_volt[11:8] <= i_byte[3:0];
                    r_pos             <= POS_VLOW;
                end
                POS_VLOW: begin
                    r_pend_volt[7:0] <= i_byte;
                    r_pos            <= POS_CNT0;
                end
                POS_CNT0, POS_CNT1, POS_CNT2, POS_CNT3: begin
                    r_pend_count <= {r_pend_count[COUNT_W-BYTE_W-1:0], i_byte};
                    r_pos        <= t_pos'(r_pos + 4'd1);
                end
                POS_END: begin
                    if (i_byte == END_MARK) begin
                        r_acc_mode <= r_pend_mode;
                    end
                    r_pos <= POS_SYNC1;
                end
                default: begin
                    r_pos <= POS_SYNC1;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/mfd_out_reg.sv
module mfd_out_reg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  mfd_pkg::t_result                i_result,
    output logic                            o_free,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mfd_pkg::OUT_TDATA_W-1:0] o_data,
    output logic                            o_user
);
    import mfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = {r_result.freq_count, r_result.voltage_code, r_result.range_mode};
    assign o_user  = r_result.mode_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: hw/rtl/measurement_frame_decoder_unit.sv
// Channel   Direction  tdata                                      tuser
// s_axis    in         [7:0] rx_byte                              -
// m_axis    out        [3:0] range_mode, [15:4] voltage_code,     [0] mode_changed
//                      [47:16] freq_count
//
// Each received byte passes an input register, one step of the frame
// decoder and, on a good end byte, the result register.
// One byte is taken every cycle while the result register is free or drained.
// Reset returns the decoder to the first sync byte and clears the last mode.
// A stalled m_axis holds its word; bytes that give no result keep flowing
// until a second result would be needed.
module measurement_frame_decoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] range_mode, [15:4] voltage_code, [47:16] freq_count
    output logic [mfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tuser    // [0] mode_changed
);
    import mfd_pkg::*;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              step;
    logic              emit;
    logic              out_free;
    t_result           result;

    // A byte that completes a frame waits until the result register can take it.
    assign step = in_valid && (!emit || out_free);

    mfd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_valid (in_valid),
        .i_take  (step),
        .o_byte  (in_byte)
    );

    mfd_deframer u_deframer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (in_byte),
        .i_step   (step),
        .o_emit   (emit),
        .o_result (result)
    );

    mfd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && emit),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_user   (m_axis_tuser)
    );

endmodule
